@@ src/gha_pkg.sv @@
// Shared constants, types and codes of the generational handle allocator.
package gha_pkg;

	localparam int SLOT_COUNT = 1024;
	localparam int GEN_W      = 16;
	localparam int IDX_W      = $clog2(SLOT_COUNT);
	localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
	localparam int MODE_W     = 2;
	localparam int STATUS_W   = 2;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [MODE_W-1:0] MODE_CREATE  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DESTROY = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CHECK   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd3;

	typedef enum logic [1:0] {
		OP_CREATE,
		OP_DESTROY,
		OP_CHECK,
		OP_CLEAR
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] index;
		logic [GEN_W-1:0] generation;
	} cmd_t;

	typedef struct packed {
		status_t          status;
		logic [IDX_W-1:0] index;
		logic [GEN_W-1:0] generation;
		logic [CNT_W-1:0] live_count;
	} res_t;

	typedef struct packed {
		logic             alive;
		logic [GEN_W-1:0] generation;
	} slot_word_t;

	typedef struct packed {
		logic [IDX_W-1:0] index;
		logic [GEN_W-1:0] generation;
	} stack_word_t;

endpackage

@@ src/gha_front.sv @@
// Front end: accepts items, decodes the mode and queues commands for the back end.
module gha_front import gha_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [MODE_W-1:0] mode,
	input  logic [IDX_W-1:0] handle_index,
	input  logic [GEN_W-1:0] handle_generation,
	output logic             cmd_valid,
	input  logic             cmd_ready,
	output cmd_t             cmd
);

	cmd_t              buf_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	cmd_t              cmd_in;
	logic              do_push;
	logic              do_pop;

	always_comb begin
		unique case (mode)
			MODE_CREATE:  cmd_in.op = OP_CREATE;
			MODE_DESTROY: cmd_in.op = OP_DESTROY;
			MODE_CHECK:   cmd_in.op = OP_CHECK;
			MODE_CLEAR:   cmd_in.op = OP_CLEAR;
			default:      cmd_in.op = OP_CLEAR;
		endcase
		cmd_in.index      = handle_index;
		cmd_in.generation = handle_generation;
	end

	assign full      = (cnt_q == QCNT_W'(QDEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = buf_q[rd_q];
	assign do_push   = push & ~full;
	assign do_pop    = cmd_valid & cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!do_push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wr_q] <= cmd_in;
		end
	end

endmodule

@@ src/gha_back.sv @@
// Back end: slot memory, free stack and counters, one command at a time.
module gha_back import gha_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,
	input  logic res_full,
	output logic res_push,
	output res_t res
);

	typedef enum logic {
		S_ISSUE,
		S_EXEC
	} state_t;

	state_t           state_q;
	cmd_t             cmd_q;
	logic [CNT_W-1:0] free_top_q;
	logic [CNT_W-1:0] high_water_q;
	logic [CNT_W-1:0] alive_q;

	slot_word_t  slot_mem [SLOT_COUNT];
	stack_word_t stack_mem [SLOT_COUNT];
	slot_word_t  slot_rd_q;
	stack_word_t stack_rd_q;

	logic             issue;
	logic [CNT_W-1:0] top_dec;
	logic [IDX_W-1:0] stack_raddr;
	logic             from_stack;
	logic             from_fresh;
	logic             handle_ok;
	logic             destroy_ok;
	logic [GEN_W-1:0] gen_inc;
	logic [GEN_W-1:0] gen_new;
	logic             slot_we;
	logic [IDX_W-1:0] slot_waddr;
	slot_word_t       slot_wdata;
	logic             stack_we;

	assign issue       = (state_q == S_ISSUE) && cmd_valid && !res_full;
	assign cmd_ready   = issue;
	assign top_dec     = free_top_q - CNT_W'(1);
	assign stack_raddr = top_dec[IDX_W-1:0];

	assign from_stack = (free_top_q != '0);
	assign from_fresh = !from_stack && (high_water_q < CNT_W'(SLOT_COUNT));
	assign handle_ok  = (cmd_q.generation != '0)
		&& ({1'b0, cmd_q.index} < high_water_q)
		&& slot_rd_q.alive
		&& (slot_rd_q.generation == cmd_q.generation);
	assign destroy_ok = handle_ok && (free_top_q < CNT_W'(SLOT_COUNT));
	assign gen_inc    = stack_rd_q.generation + GEN_W'(1);
	assign gen_new    = (gen_inc == '0) ? GEN_W'(1) : gen_inc;

	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = cmd_q.index;
		slot_wdata = '{alive: 1'b0, generation: slot_rd_q.generation};
		stack_we   = 1'b0;
		res.status     = ST_OK;
		res.index      = '0;
		res.generation = '0;
		res.live_count = alive_q;
		if (state_q == S_EXEC) begin
			case (cmd_q.op)
				OP_CREATE: begin
					if (from_stack) begin
						slot_we        = 1'b1;
						slot_waddr     = stack_rd_q.index;
						slot_wdata     = '{alive: 1'b1, generation: gen_new};
						res.index      = stack_rd_q.index;
						res.generation = gen_new;
						res.live_count = alive_q + CNT_W'(1);
					end else if (from_fresh) begin
						slot_we        = 1'b1;
						slot_waddr     = high_water_q[IDX_W-1:0];
						slot_wdata     = '{alive: 1'b1, generation: GEN_W'(1)};
						res.index      = high_water_q[IDX_W-1:0];
						res.generation = GEN_W'(1);
						res.live_count = alive_q + CNT_W'(1);
					end else begin
						res.status = ST_FULL;
					end
				end
				OP_DESTROY: begin
					res.index = cmd_q.index;
					if (destroy_ok) begin
						slot_we  = 1'b1;
						stack_we = 1'b1;
						if (alive_q != '0) begin
							res.live_count = alive_q - CNT_W'(1);
						end
					end else begin
						res.status = ST_INVALID;
					end
				end
				OP_CHECK: begin
					res.index  = cmd_q.index;
					res.status = handle_ok ? ST_OK : ST_INVALID;
				end
				OP_CLEAR: begin
					res.live_count = '0;
				end
				default: begin
				end
			endcase
		end
	end

	assign res_push = (state_q == S_EXEC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_ISSUE;
			free_top_q   <= '0;
			high_water_q <= '0;
			alive_q      <= '0;
		end else begin
			unique case (state_q)
				S_ISSUE: begin
					if (issue) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_ISSUE;
					alive_q <= res.live_count;
					case (cmd_q.op)
						OP_CREATE: begin
							if (from_stack) begin
								free_top_q <= top_dec;
							end else if (from_fresh) begin
								high_water_q <= high_water_q + CNT_W'(1);
							end
						end
						OP_DESTROY: begin
							if (destroy_ok) begin
								free_top_q <= free_top_q + CNT_W'(1);
							end
						end
						OP_CLEAR: begin
							free_top_q   <= '0;
							high_water_q <= '0;
						end
						default: begin
						end
					endcase
				end
				default: begin
					state_q <= S_ISSUE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			cmd_q <= cmd;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			slot_rd_q <= slot_mem[cmd.index];
		end
		if (slot_we) begin
			slot_mem[slot_waddr] <= slot_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			stack_rd_q <= stack_mem[stack_raddr];
		end
		if (stack_we) begin
			stack_mem[free_top_q[IDX_W-1:0]] <= '{index: cmd_q.index,
				generation: slot_rd_q.generation};
		end
	end

endmodule

@@ src/gha_res_q.sv @@
// Result queue: holds finished items until the consumer pops them.
module gha_res_q import gha_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             res_push,
	input  res_t             res,
	output logic             res_full,
	input  logic             pop,
	output logic             empty,
	output logic [STATUS_W-1:0] status,
	output logic [IDX_W-1:0] out_index,
	output logic [GEN_W-1:0] out_generation,
	output logic [CNT_W-1:0] live_count
);

	res_t              buf_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;
	res_t              head;

	assign res_full = (cnt_q == QCNT_W'(QDEPTH));
	assign empty    = (cnt_q == '0);
	assign do_push  = res_push & ~res_full;
	assign do_pop   = pop & ~empty;

	assign head           = buf_q[rd_q];
	assign status         = head.status;
	assign out_index      = head.index;
	assign out_generation = head.generation;
	assign live_count     = head.live_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!do_push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wr_q] <= res;
		end
	end

endmodule

@@ src/generational_handle_allocator_top.sv @@
// Top level of the generational handle allocator.
//
//  Channel  | Handshake          | Fields
//  ---------+--------------------+---------------------------------------------------
//  input    | push / full        | mode, handle_index, handle_generation
//  result   | pop / empty        | status, out_index, out_generation, live_count
//
// In the back end, S_ISSUE reads the slot memory and the free stack for an item;
// S_EXEC computes the result and writes the slot memory and, on a destroy, the stack.
// Reset clears only state, counters and queue pointers; memories need no clearing.
// Two-entry queues on each side let the producer and the consumer stall independently.
module generational_handle_allocator_top import gha_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [MODE_W-1:0]   mode,
	input  logic [IDX_W-1:0]    handle_index,
	input  logic [GEN_W-1:0]    handle_generation,
	input  logic                pop,
	output logic                empty,
	output logic [STATUS_W-1:0] status,
	output logic [IDX_W-1:0]    out_index,
	output logic [GEN_W-1:0]    out_generation,
	output logic [CNT_W-1:0]    live_count
);

	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;
	logic res_full;
	logic res_push;
	res_t res;

	gha_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.push              (push),
		.full              (full),
		.mode              (mode),
		.handle_index      (handle_index),
		.handle_generation (handle_generation),
		.cmd_valid         (cmd_valid),
		.cmd_ready         (cmd_ready),
		.cmd               (cmd)
	);

	gha_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res)
	);

	gha_res_q u_res_q (
		.clk            (clk),
		.arst_n         (arst_n),
		.res_push       (res_push),
		.res            (res),
		.res_full       (res_full),
		.pop            (pop),
		.empty          (empty),
		.status         (status),
		.out_index      (out_index),
		.out_generation (out_generation),
		.live_count     (live_count)
	);

endmodule

@@ src/gha_checker.sv @@
// Port-level checker for the allocator and its bind to the top level.
module gha_checker import gha_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                pop,
	input logic                empty,
	input logic [STATUS_W-1:0] status,
	input logic [IDX_W-1:0]    out_index,
	input logic [GEN_W-1:0]    out_generation,
	input logic [CNT_W-1:0]    live_count
);

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (status == ST_OK || status == ST_INVALID || status == ST_FULL))
		else $error("Result status carries an unused code.");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == ST_FULL) |-> (out_index == '0 && out_generation == '0))
		else $error("A full create returned a nonzero handle.");

	a_gen_success: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_generation != '0) |-> (status == ST_OK))
		else $error("A returned generation came with a failing status.");

	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (live_count <= CNT_W'(SLOT_COUNT)))
		else $error("Live count exceeds the slot count.");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_generation) && $stable(live_count)))
		else $error("A waiting item changed before it was popped.");

endmodule

bind generational_handle_allocator_top gha_checker u_gha_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.pop            (pop),
	.empty          (empty),
	.status         (status),
	.out_index      (out_index),
	.out_generation (out_generation),
	.live_count     (live_count)
);

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the generational handle allocator, with directed and random items.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import gha_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_ITEMS   = 420;
	localparam int PRESSURE_HOLD  = 400;
	localparam int DRAIN_CYCLES   = 20;

	logic                clk;
	logic                arst_n;
	logic                push;
	logic                full;
	logic [MODE_W-1:0]   mode;
	logic [IDX_W-1:0]    handle_index;
	logic [GEN_W-1:0]    handle_generation;
	logic                pop;
	logic                empty;
	logic [STATUS_W-1:0] status;
	logic [IDX_W-1:0]    out_index;
	logic [GEN_W-1:0]    out_generation;
	logic [CNT_W-1:0]    live_count;

	logic [GEN_W-1:0] pool_generation [SLOT_COUNT];
	bit               pool_alive      [SLOT_COUNT];
	logic [IDX_W-1:0] free_slots      [SLOT_COUNT];
	int               free_depth   = 0;
	int               high_water   = 0;
	int               live_total   = 0;
	int               written_mark = 0;

	res_t expected_results [$];

	int fail_count        = 0;
	int items_sent        = 0;
	int results_checked   = 0;
	int full_answers      = 0;
	int invalid_answers   = 0;
	int full_stall_cycles = 0;
	bit idle_on           = 1'b1;
	int hold_request      = 0;

	generational_handle_allocator_top DUT (
		.clk               (clk),
		.arst_n            (arst_n),
		.push              (push),
		.full              (full),
		.mode              (mode),
		.handle_index      (handle_index),
		.handle_generation (handle_generation),
		.pop               (pop),
		.empty             (empty),
		.status            (status),
		.out_index         (out_index),
		.out_generation    (out_generation),
		.live_count        (live_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic bit handle_live(int idx, logic [GEN_W-1:0] gen);
		return gen != '0 && idx < high_water && pool_alive[idx] && pool_generation[idx] == gen;
	endfunction

	function automatic res_t apply_to_pool(op_t op, logic [IDX_W-1:0] idx,
			logic [GEN_W-1:0] gen);
		res_t r;
		int slot;
		r = '0;
		r.status = ST_OK;
		slot = -1;
		case (op)
			OP_CREATE: begin
				if (free_depth > 0) begin
					free_depth--;
					slot = int'(free_slots[free_depth]);
					pool_generation[slot] = pool_generation[slot] + 1'b1;
					if (pool_generation[slot] == '0)
						pool_generation[slot] = GEN_W'(1);
				end else if (high_water < SLOT_COUNT) begin
					slot = high_water;
					high_water++;
					pool_generation[slot] = GEN_W'(1);
					if (high_water > written_mark)
						written_mark = high_water;
				end
				if (slot < 0) begin
					r.status = ST_FULL;
				end else begin
					pool_alive[slot] = 1'b1;
					live_total++;
					r.index = IDX_W'(slot);
					r.generation = pool_generation[slot];
				end
			end
			OP_DESTROY: begin
				r.index = idx;
				if (handle_live(int'(idx), gen)) begin
					pool_alive[idx] = 1'b0;
					free_slots[free_depth] = idx;
					free_depth++;
					live_total--;
				end else begin
					r.status = ST_INVALID;
				end
			end
			OP_CHECK: begin
				r.index = idx;
				if (!handle_live(int'(idx), gen))
					r.status = ST_INVALID;
			end
			OP_CLEAR: begin
				foreach (pool_alive[i])
					pool_alive[i] = 1'b0;
				free_depth = 0;
				high_water = 0;
				live_total = 0;
			end
		endcase
		r.live_count = CNT_W'(live_total);
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic int noise_index();
		return written_mark > 0 ? $urandom_range(0, written_mark - 1) : 0;
	endfunction

	function automatic void pick_handle(output logic [IDX_W-1:0] idx,
			output logic [GEN_W-1:0] gen);
		int kind;
		int slot;
		kind = $urandom_range(0, 99);
		slot = noise_index();
		gen = GEN_W'($urandom);
		if (kind < 5)
			gen = '0;
		if (high_water > 0 && kind >= 30) begin
			slot = $urandom_range(0, high_water - 1);
			for (int tries = 0; tries < 8 && !pool_alive[slot]; tries++)
				slot = $urandom_range(0, high_water - 1);
			gen = pool_generation[slot];
			if (kind < 45)
				gen = gen - 1'b1;
		end
		idx = IDX_W'(slot);
	endfunction

	task automatic send_item(op_t op, logic [IDX_W-1:0] idx, logic [GEN_W-1:0] gen);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		mode <= op;
		handle_index <= idx;
		handle_generation <= gen;
		do begin
			@(posedge clk);
			if (full)
				full_stall_cycles++;
		end while (full);
		expected_results.insert(expected_results.size(), apply_to_pool(op, idx, gen));
		items_sent++;
	endtask

	task automatic send_create();
		send_item(OP_CREATE, IDX_W'(noise_index()), GEN_W'($urandom));
	endtask

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endfunction

	task automatic check_result();
		res_t want;
		if (expected_results.size() == 0) begin
			$error("Result with no item waiting: status %0d, index %0d, generation %0d",
				status, out_index, out_generation);
			fail_count++;
		end else begin
			want = expected_results.pop_front();
			results_checked++;
			if (want.status == ST_FULL)
				full_answers++;
			if (want.status == ST_INVALID)
				invalid_answers++;
			compare_field("status", 32'(want.status), 32'(status));
			compare_field("out_index", 32'(want.index), 32'(out_index));
			compare_field("out_generation", 32'(want.generation), 32'(out_generation));
			compare_field("live_count", 32'(want.live_count), 32'(live_count));
		end
	endtask

	initial begin
		int stall;
		int r;
		pop <= 1'b0;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty)
				check_result();
			if (hold_request > 0) begin
				hold_request--;
				pop <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
				if (idle_on) begin
					r = $urandom_range(0, 99);
					if (r < 10)
						stall = $urandom_range(1, 3);
					else if (r < 12)
						stall = $urandom_range(15, 50);
				end
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$error("No item moved for %0d cycles", WATCHDOG_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	task automatic test_handle_lifecycle();
		repeat (4) send_item(OP_CREATE, '0, '0);
		send_item(OP_CHECK, 1, 1);
		send_item(OP_CHECK, 1, 0);
		send_item(OP_CHECK, 1, 2);
		send_item(OP_DESTROY, 1, 1);
		send_item(OP_DESTROY, 1, 1);
		send_item(OP_CHECK, 1, 1);
		send_item(OP_DESTROY, 0, 1);
		send_item(OP_DESTROY, 2, 1);
		repeat (4) send_create();
		send_item(OP_CLEAR, 3, 1);
		send_item(OP_CHECK, 2, 2);
		send_item(OP_DESTROY, 0, 2);
		send_create();
		send_item(OP_CHECK, 0, 1);
	endtask

	task automatic test_pool_full();
		send_item(OP_CLEAR, '0, '0);
		repeat (SLOT_COUNT + 2) send_create();
		send_item(OP_DESTROY, SLOT_COUNT - 1, 1);
		send_item(OP_DESTROY, SLOT_COUNT / 2, 1);
		send_item(OP_DESTROY, 0, 1);
		send_item(OP_DESTROY, SLOT_COUNT - 1, 1);
		send_item(OP_CHECK, SLOT_COUNT - 1, '1);
		repeat (4) send_create();
		send_item(OP_CHECK, SLOT_COUNT - 1, 2);
	endtask

	task automatic test_backpressure();
		logic [IDX_W-1:0] idx;
		logic [GEN_W-1:0] gen;
		idle_on = 1'b0;
		hold_request = PRESSURE_HOLD;
		repeat (24) begin
			pick_handle(idx, gen);
			if ($urandom_range(0, 1))
				send_create();
			else
				send_item(OP_CHECK, idx, gen);
		end
		idle_on = 1'b1;
	endtask

	task automatic test_random_traffic();
		logic [IDX_W-1:0] idx;
		logic [GEN_W-1:0] gen;
		int r;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 250 == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			pick_handle(idx, gen);
			r = $urandom_range(0, 99);
			if (r < 45)
				send_item(OP_CREATE, idx, gen);
			else if (r < 70)
				send_item(OP_DESTROY, idx, gen);
			else if (r < 99)
				send_item(OP_CHECK, idx, gen);
			else
				send_item(OP_CLEAR, idx, gen);
		end
		idle_on = 1'b1;
	endtask

	initial begin
		push <= 1'b0;
		mode <= MODE_CREATE;
		handle_index <= '0;
		handle_generation <= '0;
		arst_n <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_handle_lifecycle();
		test_pool_full();
		test_backpressure();
		test_random_traffic();
		push <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d items and checked %0d results, %0d invalid-handle and %0d pool-full.",
			items_sent, results_checked, invalid_answers, full_answers);
		$display("Covered handle reuse, a full pool and a %0d-cycle result stall (%0d full cycles).",
			PRESSURE_HOLD, full_stall_cycles);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
